// ===== rtl/core/scf_pkg.sv =====
// Package with the widths, types and helper functions of the sample clip-or-fold core.
package scf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SPAN_BITS   = SAMPLE_BITS + 1;
    localparam int REM_BITS    = SAMPLE_BITS + 2;
    localparam int WIDE_BITS   = SAMPLE_BITS + 3;
    localparam int DIV_STEPS   = REM_BITS;
    localparam int LATENCY     = DIV_STEPS + 6;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WIDE_BITS-1:0]   wide_t;
    typedef logic [SPAN_BITS-1:0]          span_t;
    typedef logic [REM_BITS-1:0]           rem_t;

    typedef struct packed {
        sample_t pass_val;
        wide_t   sum;
        span_t   span;
        logic    use_fold;
        logic    zero_span;
    } side_t;

    typedef struct packed {
        rem_t  dividend;
        rem_t  divisor;
        side_t side;
    } div_t;

    function automatic wide_t sext_wide(input sample_t v);
        sext_wide = {{(WIDE_BITS - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    function automatic wide_t zext_span(input span_t v);
        zext_span = {{(WIDE_BITS - SPAN_BITS){1'b0}}, v};
    endfunction

endpackage

// ===== rtl/core/scf_front.sv =====
// Front stages: bound ordering, clipping, doubled-unit offsets and remainder operands.
module scf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  scf_pkg::sample_t  sample_in,
    input  scf_pkg::sample_t  upper_bound,
    input  scf_pkg::sample_t  lower_bound,
    input  logic              sample_invalid,
    input  logic              fold_mode,
    output logic              out_valid,
    output scf_pkg::div_t     out_data
);

    logic             s1_valid_reg;
    scf_pkg::sample_t s1_hi_reg;
    scf_pkg::sample_t s1_lo_reg;
    scf_pkg::sample_t s1_s_reg;
    logic             s1_inv_reg;
    logic             s1_mode_reg;

    logic             s2_valid_reg;
    scf_pkg::wide_t   s2_sum_reg;
    scf_pkg::wide_t   s2_x_reg;
    scf_pkg::span_t   s2_span_reg;
    scf_pkg::sample_t s2_pass_reg;
    logic             s2_inv_reg;
    logic             s2_mode_reg;

    logic             s3_valid_reg;
    scf_pkg::div_t    s3_data_reg;

    logic             swap;
    scf_pkg::wide_t   hi_w;
    scf_pkg::wide_t   lo_w;
    scf_pkg::wide_t   span_w;
    scf_pkg::sample_t clip_val;
    scf_pkg::span_t   span_next;
    scf_pkg::wide_t   tw;
    scf_pkg::wide_t   diff;
    scf_pkg::wide_t   adiff;
    logic             outside;
    logic [scf_pkg::SPAN_BITS+1:0] div4;
    scf_pkg::div_t    s3_data_next;

    assign swap = upper_bound < lower_bound;

    always_comb
    begin
        hi_w      = scf_pkg::sext_wide(s1_hi_reg);
        lo_w      = scf_pkg::sext_wide(s1_lo_reg);
        span_w    = hi_w - lo_w;
        span_next = span_w[scf_pkg::SPAN_BITS-1:0];
        if (s1_s_reg < s1_lo_reg)
        begin
            clip_val = s1_lo_reg;
        end
        else if (s1_s_reg > s1_hi_reg)
        begin
            clip_val = s1_hi_reg;
        end
        else
        begin
            clip_val = s1_s_reg;
        end
    end

    always_comb
    begin
        tw      = scf_pkg::zext_span(s2_span_reg);
        outside = (s2_x_reg > tw) || (s2_x_reg < -tw);
        diff    = s2_x_reg - tw;
        adiff   = diff[scf_pkg::WIDE_BITS-1] ? -diff : diff;
        div4    = {s2_span_reg, 2'b00};
        s3_data_next.dividend       = adiff[scf_pkg::REM_BITS-1:0];
        s3_data_next.divisor        = div4[scf_pkg::REM_BITS-1:0];
        s3_data_next.side.pass_val  = s2_pass_reg;
        s3_data_next.side.sum       = s2_sum_reg;
        s3_data_next.side.span      = s2_span_reg;
        s3_data_next.side.use_fold  = s2_mode_reg && outside && !s2_inv_reg;
        s3_data_next.side.zero_span = (s2_span_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_hi_reg   <= swap ? lower_bound : upper_bound;
            s1_lo_reg   <= swap ? upper_bound : lower_bound;
            s1_s_reg    <= sample_in;
            s1_inv_reg  <= sample_invalid;
            s1_mode_reg <= fold_mode;
        end
        if (s1_valid_reg)
        begin
            s2_sum_reg  <= hi_w + lo_w;
            s2_x_reg    <= (scf_pkg::sext_wide(s1_s_reg) <<< 1) - hi_w - lo_w;
            s2_span_reg <= span_next;
            s2_pass_reg <= s1_inv_reg ? '0 : clip_val;
            s2_inv_reg  <= s1_inv_reg;
            s2_mode_reg <= s1_mode_reg;
        end
        if (s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ===== rtl/core/scf_rem_pipe.sv =====
// Pipelined restoring remainder unit, one dividend bit per stage.
module scf_rem_pipe
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  scf_pkg::div_t   in_data,
    output logic            out_valid,
    output scf_pkg::rem_t   out_rem,
    output scf_pkg::side_t  out_side
);

    localparam int LAST = scf_pkg::DIV_STEPS - 1;

    logic           valid_reg [scf_pkg::DIV_STEPS];
    scf_pkg::rem_t  rem_reg   [scf_pkg::DIV_STEPS];
    scf_pkg::rem_t  dvd_reg   [scf_pkg::DIV_STEPS];
    scf_pkg::rem_t  dvs_reg   [scf_pkg::DIV_STEPS];
    scf_pkg::side_t side_reg  [scf_pkg::DIV_STEPS];

    genvar g;
    for (g = 0; g < scf_pkg::DIV_STEPS; g++)
    begin : g_step
        logic                        src_valid;
        scf_pkg::rem_t               src_rem;
        scf_pkg::rem_t               src_dvd;
        scf_pkg::rem_t               src_dvs;
        scf_pkg::side_t              src_side;
        logic [scf_pkg::REM_BITS:0]  trial;
        logic [scf_pkg::REM_BITS:0]  reduced;
        scf_pkg::rem_t               rem_next;

        if (g == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_dvd   = in_data.dividend;
            assign src_dvs   = in_data.divisor;
            assign src_side  = in_data.side;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[g-1];
            assign src_rem   = rem_reg[g-1];
            assign src_dvd   = dvd_reg[g-1];
            assign src_dvs   = dvs_reg[g-1];
            assign src_side  = side_reg[g-1];
        end

        always_comb
        begin
            trial   = {src_rem, src_dvd[scf_pkg::REM_BITS-1]};
            reduced = trial - {1'b0, src_dvs};
            if (trial >= {1'b0, src_dvs})
            begin
                rem_next = reduced[scf_pkg::REM_BITS-1:0];
            end
            else
            begin
                rem_next = trial[scf_pkg::REM_BITS-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (src_valid)
            begin
                rem_reg[g]  <= rem_next;
                dvd_reg[g]  <= {src_dvd[scf_pkg::REM_BITS-2:0], 1'b0};
                dvs_reg[g]  <= src_dvs;
                side_reg[g] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_rem   = rem_reg[LAST];
    assign out_side  = side_reg[LAST];

endmodule

// ===== rtl/core/scf_back.sv =====
// Back stages: reflection from the remainder, recentering, halving and result select.
module scf_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  scf_pkg::rem_t     in_rem,
    input  scf_pkg::side_t    in_side,
    output logic              done,
    output scf_pkg::sample_t  sample_out
);

    logic             e1_valid_reg;
    scf_pkg::wide_t   e1_u_reg;
    scf_pkg::side_t   e1_side_reg;

    logic             e2_valid_reg;
    scf_pkg::wide_t   e2_y_reg;
    scf_pkg::side_t   e2_side_reg;

    logic             e3_valid_reg;
    scf_pkg::sample_t e3_out_reg;

    scf_pkg::wide_t   rem_w;
    scf_pkg::wide_t   gap;
    scf_pkg::wide_t   y_next;
    scf_pkg::wide_t   total;
    scf_pkg::sample_t out_next;

    always_comb
    begin
        rem_w  = {1'b0, in_rem};
        gap    = rem_w - (scf_pkg::zext_span(in_side.span) <<< 1);
        y_next = e1_side_reg.zero_span ? '0
                 : e1_u_reg - scf_pkg::zext_span(e1_side_reg.span);
        total  = e2_y_reg + e2_side_reg.sum;
        out_next = e2_side_reg.use_fold ? total[scf_pkg::SAMPLE_BITS:1]
                   : e2_side_reg.pass_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg <= in_valid;
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            e1_u_reg    <= gap[scf_pkg::WIDE_BITS-1] ? -gap : gap;
            e1_side_reg <= in_side;
        end
        if (e1_valid_reg)
        begin
            e2_y_reg    <= y_next;
            e2_side_reg <= e1_side_reg;
        end
        if (e2_valid_reg)
        begin
            e3_out_reg <= out_next;
        end
    end

    assign done       = e3_valid_reg;
    assign sample_out = e3_out_reg;

endmodule

// ===== rtl/core/sample_clip_or_fold_core.sv =====
// Top level of the sample clip-or-fold core.
//
// Channel   Direction  Handshake             Payload
// input     in         start high, busy low  sample_in, upper_bound, lower_bound,
//                                            sample_invalid
// result    out        done strobe, 1 cycle  sample_out
// config    in         cfg_wr_en             cfg_wr_data (fold_mode)
//
// One item is accepted in every cycle; busy is always low.
// Each item passes the three front stages, the remainder pipeline with one stage per
// dividend bit, and the three back stages before its result appears on sample_out.
// Reset clears the valid bits of every stage and the fold_mode register.
// The receiver cannot stall, so the pipeline never holds an item.
module sample_clip_or_fold_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  scf_pkg::sample_t  sample_in,
    input  scf_pkg::sample_t  upper_bound,
    input  scf_pkg::sample_t  lower_bound,
    input  logic              sample_invalid,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    output logic              done,
    output scf_pkg::sample_t  sample_out
);

    logic           fold_mode_reg;
    logic           accept;
    logic           front_valid;
    scf_pkg::div_t  front_data;
    logic           rem_valid;
    scf_pkg::rem_t  rem_val;
    scf_pkg::side_t rem_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            fold_mode_reg <= cfg_wr_data;
        end
    end

    scf_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .sample_in      (sample_in),
        .upper_bound    (upper_bound),
        .lower_bound    (lower_bound),
        .sample_invalid (sample_invalid),
        .fold_mode      (fold_mode_reg),
        .out_valid      (front_valid),
        .out_data       (front_data)
    );

    scf_rem_pipe u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (rem_valid),
        .out_rem   (rem_val),
        .out_side  (rem_side)
    );

    scf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rem_valid),
        .in_rem     (rem_val),
        .in_side    (rem_side),
        .done       (done),
        .sample_out (sample_out)
    );

endmodule

// ===== rtl/core/scf_checker.sv =====
// Port-level checker of the sample clip-or-fold core and its bind to the top level.
module scf_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  scf_pkg::sample_t  upper_bound,
    input  scf_pkg::sample_t  lower_bound,
    input  logic              sample_invalid,
    input  logic              done,
    input  scf_pkg::sample_t  sample_out
);

    localparam int LAT = scf_pkg::LATENCY;

    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy was raised although the core never stalls.");

    a_done_has_item : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("A result appeared without an item accepted at the fixed latency.");

    a_item_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("An accepted item gave no result at the fixed latency.");

    a_bounded_out : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(sample_invalid, LAT)) |->
            ((sample_out >= $past(lower_bound, LAT) && sample_out <= $past(upper_bound, LAT))
          || (sample_out >= $past(upper_bound, LAT) && sample_out <= $past(lower_bound, LAT))))
        else $error("A valid result fell outside its bounds.");

    a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(sample_invalid, LAT)) |-> (sample_out == '0))
        else $error("An invalid item did not give zero.");

endmodule

bind sample_clip_or_fold_core scf_checker u_scf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .upper_bound    (upper_bound),
    .lower_bound    (lower_bound),
    .sample_invalid (sample_invalid),
    .done           (done),
    .sample_out     (sample_out)
);

// ===== tb/sv/clip_fold_checker.sv =====
// Checker that predicts every clipped or folded sample and compares it with the core's output.
`timescale 1ns / 100ps

module clip_fold_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  scf_pkg::sample_t sample_in,
    input  scf_pkg::sample_t upper_bound,
    input  scf_pkg::sample_t lower_bound,
    input  logic             sample_invalid,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             done,
    input  scf_pkg::sample_t sample_out,
    output int               mismatch_count,
    output int               samples_in_flight
);

    typedef scf_pkg::sample_t sample_t;

    sample_t expected_samples[$];
    logic    fold_enabled;
    int      fail_total;
    sample_t oldest_sample;

    function automatic sample_t clip_or_fold(input sample_t smp, input sample_t bound_a,
                                             input sample_t bound_b, input logic invalid,
                                             input logic fold);
        longint ceiling;
        longint floor_val;
        longint value;
        longint centre_sum;
        longint offset;
        longint span;
        longint folded;
        longint phase;
        longint outcome;
        value     = smp;
        ceiling   = bound_a;
        floor_val = bound_b;
        if (ceiling < floor_val)
        begin
            ceiling   = bound_b;
            floor_val = bound_a;
        end
        if (invalid)
        begin
            outcome = 0;
        end
        else if (fold)
        begin
            centre_sum = ceiling + floor_val;
            offset     = 2 * value - centre_sum;
            span       = ceiling - floor_val;
            folded     = offset;
            if (offset < -span || offset > span)
            begin
                if (span != 0)
                begin
                    phase  = offset - span;
                    phase  = (phase < 0) ? -phase : phase;
                    phase  = phase % (4 * span);
                    folded = phase - 2 * span;
                    folded = ((folded < 0) ? -folded : folded) - span;
                end
                else
                begin
                    folded = 0;
                end
            end
            outcome = (folded + centre_sum) / 2;
        end
        else
        begin
            outcome = value;
            if (outcome < floor_val)
                outcome = floor_val;
            else if (outcome > ceiling)
                outcome = ceiling;
        end
        clip_or_fold = sample_t'(outcome);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_enabled = 1'b0;
            expected_samples.delete();
            fail_total = 0;
            mismatch_count <= 0;
            samples_in_flight <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                fold_enabled = cfg_wr_data;
            if (start && !busy)
                expected_samples.push_back(clip_or_fold(sample_in, upper_bound, lower_bound,
                                                        sample_invalid, fold_enabled));
            if (done)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample_out, expected none, actual %0d",
                             $time, sample_out);
                    fail_total = fail_total + 1;
                end
                else
                begin
                    oldest_sample = expected_samples.pop_front();
                    if (sample_out !== oldest_sample)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, oldest_sample, sample_out);
                        fail_total = fail_total + 1;
                    end
                end
            end
            mismatch_count <= fail_total;
            samples_in_flight <= expected_samples.size();
        end
    end

endmodule

// ===== tb/sv/sample_clip_or_fold_core_test.sv =====
// Testbench top that drives directed and random samples into the clip-or-fold core.
`timescale 1ns / 100ps

module sample_clip_or_fold_core_test;

    typedef scf_pkg::sample_t sample_t;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 6;
    localparam longint MAX_VAL  = (64'sd1 <<< (scf_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint MIN_VAL  = -(64'sd1 <<< (scf_pkg::SAMPLE_BITS - 1));

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t sample_in;
    sample_t upper_bound;
    sample_t lower_bound;
    logic    sample_invalid;
    logic    cfg_wr_en;
    logic    cfg_wr_data;
    logic    done;
    sample_t sample_out;
    int      mismatch_count;
    int      samples_in_flight;
    int      stall_cycles;

    sample_clip_or_fold_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_in      (sample_in),
        .upper_bound    (upper_bound),
        .lower_bound    (lower_bound),
        .sample_invalid (sample_invalid),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .sample_out     (sample_out)
    );

    clip_fold_checker i_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .sample_in         (sample_in),
        .upper_bound       (upper_bound),
        .lower_bound       (lower_bound),
        .sample_invalid    (sample_invalid),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .done              (done),
        .sample_out        (sample_out),
        .mismatch_count    (mismatch_count),
        .samples_in_flight (samples_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sample_clip_or_fold_core verification failed");
                $finish;
            end
        end
    end

    function automatic sample_t clamp_sample(input longint v);
        if (v > MAX_VAL)
            clamp_sample = sample_t'(MAX_VAL);
        else if (v < MIN_VAL)
            clamp_sample = sample_t'(MIN_VAL);
        else
            clamp_sample = sample_t'(v);
    endfunction

    function automatic sample_t pick_value();
        case ($urandom_range(0, 5))
            0:       pick_value = sample_t'(MAX_VAL);
            1:       pick_value = sample_t'(MIN_VAL);
            2:       pick_value = sample_t'(longint'($urandom_range(0, 127)) - 64);
            default: pick_value = sample_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input sample_t smp, input sample_t bound_a,
                             input sample_t bound_b, input logic invalid);
        start          <= 1'b1;
        sample_in      <= smp;
        upper_bound    <= bound_a;
        lower_bound    <= bound_b;
        sample_invalid <= invalid;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (samples_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_fold_mode(input logic fold);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fold;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_items();
        send_item(sample_t'(0), sample_t'(100), sample_t'(-100), 1'b0);
        send_item(sample_t'(MAX_VAL), sample_t'(MAX_VAL), sample_t'(MIN_VAL), 1'b0);
        send_item(sample_t'(MIN_VAL), sample_t'(MAX_VAL), sample_t'(MIN_VAL), 1'b0);
        send_item(sample_t'(MAX_VAL), sample_t'(10), sample_t'(-10), 1'b0);
        send_item(sample_t'(MIN_VAL), sample_t'(10), sample_t'(-10), 1'b0);
        send_item(sample_t'(50), sample_t'(-10), sample_t'(10), 1'b0);
        send_item(sample_t'(150), sample_t'(200), sample_t'(100), 1'b1);
        send_item(sample_t'(-5000), sample_t'(77), sample_t'(77), 1'b0);
        send_item(sample_t'(MIN_VAL), sample_t'(MAX_VAL), sample_t'(MAX_VAL), 1'b0);
        send_item(sample_t'(100), sample_t'(100), sample_t'(-3), 1'b0);
        send_item(sample_t'(13), sample_t'(5), sample_t'(2), 1'b0);
        send_item(sample_t'(MAX_VAL), sample_t'(MIN_VAL), sample_t'(MIN_VAL), 1'b0);
    endtask

    task automatic random_item();
        longint  centre;
        longint  span;
        longint  reach;
        sample_t smp;
        sample_t bound_a;
        sample_t bound_b;
        sample_t swap_tmp;
        logic    invalid;
        invalid = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                bound_a = pick_value();
                bound_b = pick_value();
                smp     = pick_value();
            end
            3:
            begin
                bound_a = pick_value();
                bound_b = bound_a;
                smp     = pick_value();
            end
            default:
            begin
                centre  = longint'(sample_t'($urandom));
                span    = (($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1 << 20))
                                                       : longint'($urandom_range(0, 40)));
                bound_b = clamp_sample(centre - span / 2);
                bound_a = clamp_sample(longint'(bound_b) + span);
                reach   = (span + 1) * longint'($urandom_range(0, 9));
                smp     = clamp_sample(centre + longint'($urandom_range(0, 2 * reach)) - reach);
            end
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            swap_tmp = bound_a;
            bound_a  = bound_b;
            bound_b  = swap_tmp;
        end
        send_item(smp, bound_a, bound_b, invalid);
    endtask

    initial
    begin
        logic phase_fold[PHASE_COUNT];
        int   phase_idle[PHASE_COUNT];
        phase_fold = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_idle = '{0, 59, 59, 9, 9, 0};
        rst_n          = 1'b0;
        start          = 1'b0;
        sample_in      = '0;
        upper_bound    = '0;
        lower_bound    = '0;
        sample_invalid = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        wait_drained();
        write_fold_mode(1'b1);
        directed_items();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained();
            write_fold_mode(phase_fold[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < phase_idle[p])
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                random_item();
            end
        end

        wait_drained();
        repeat (scf_pkg::LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0 && samples_in_flight == 0)
            $display("sample_clip_or_fold_core verification clean");
        else
            $display("sample_clip_or_fold_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/scf_pkg.sv
rtl/core/scf_front.sv
rtl/core/scf_rem_pipe.sv
rtl/core/scf_back.sv
rtl/core/sample_clip_or_fold_core.sv
rtl/core/scf_checker.sv
tb/sv/clip_fold_checker.sv
tb/sv/sample_clip_or_fold_core_test.sv
